>>> hw/rtl/smcd_pkg.sv
// smcd_pkg: shared types and constants of the switch matrix change debouncer
// word layouts, lane result types, function codes and register map
// no dependencies
package smcd_pkg;

   localparam int SmcdRows = 8;   // rows of the matrix that are scanned, 1..8
   localparam int SmcdCols = 8;   // columns per row, fixed
   localparam int SmcdSquares = 64;
   localparam int SmcdSqWidth = 6;
   localparam int SmcdColWidth = 3;
   localparam int SmcdRowWidth = 3;
   localparam int SmcdAddrWidth = 3;

   // switch bits of rows that are not scanned are forced low
   localparam logic [SmcdSquares-1:0] SmcdRowsMask = (SmcdRows >= 8) ? {SmcdSquares{1'b1}} :
      ((64'd1 << (SmcdRows * SmcdCols)) - 64'd1);

   localparam logic [15:0] SmcdDelayReset = 16'd20;

   // function codes of an input word
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_FILL = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_DELAY = 1'b0;

   typedef struct packed {
      logic        func;
      logic [63:0] switches;
      logic [7:0]  buttons;
      logic [31:0] now_ms;
   } smcd_req_type;

   typedef struct packed {
      logic        changed;
      logic [5:0]  square;
      logic        lifted;
      logic [7:0]  button_state;
      logic [63:0] board_state;
   } smcd_rsp_type;

   // what one row lane found
   typedef struct packed {
      logic                    hit;
      logic [SmcdColWidth-1:0] col;
   } smcd_lane_type;

   // merged pick over all lanes
   typedef struct packed {
      logic                   any;
      logic [SmcdSqWidth-1:0] square;
   } smcd_pick_type;

endpackage

>>> hw/rtl/switch_matrix_change_debouncer_unit.sv
// switch_matrix_change_debouncer_unit: top level of the matrix debouncer
// holds the board state, the debounce register and the result buffer
// depends on smcd_pkg, smcd_lane, smcd_merge
//
// For every input word, one row lane per matrix row compares the
// snapshot with the stored board in parallel, a merge stage picks the lowest
// row with a difference, and the board, pending square, scan time and button
// mask are updated at the edge the word is accepted, so the next word may
// follow in the very next cycle while req_ready is high. Each word yields
// exactly one result word, which is placed in an output register backed
// by a one-entry skid buffer; req_ready drops only while both hold a word. The
// debounce delay lives at byte address 0 of the APB port and should be
// written while no word is in flight.
module switch_matrix_change_debouncer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  smcd_pkg::smcd_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output smcd_pkg::smcd_rsp_type             rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [smcd_pkg::SmcdAddrWidth-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic [15:0] delay_ff, delay_in;
   logic [63:0] board_ff, board_in;
   logic [5:0]  pending_ff, pending_in;
   logic [31:0] last_scan_ff, last_scan_in;
   logic [7:0]  button_ff, button_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   smcd_pkg::smcd_rsp_type out_data_ff, out_data_in;
   smcd_pkg::smcd_rsp_type skid_data_ff, skid_data_in;

   logic                    accept;
   logic                    take;
   logic                    scan_ok;
   logic                    lifted;
   logic [31:0]             elapsed;
   logic [63:0]             sw_masked;
   logic [63:0]             sq_bit;
   smcd_pkg::smcd_rsp_type  result;
   smcd_pkg::smcd_lane_type lanes [smcd_pkg::SmcdRows];
   smcd_pkg::smcd_pick_type pick;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == smcd_pkg::CSR_IDX_DELAY) ? {16'd0, delay_ff} : 32'd0;

   always_comb begin
      delay_in = delay_ff;
      if (psel && penable && pwrite && (paddr[2] == smcd_pkg::CSR_IDX_DELAY)) begin
         delay_in = pwdata[15:0];
      end
   end

   // row lanes and merge
   assign sw_masked = req_data.switches & smcd_pkg::SmcdRowsMask;

   for (genvar r = 0; r < smcd_pkg::SmcdRows; r++) begin : g_lane
      smcd_lane u_lane (
         .sw_row    (sw_masked[r*smcd_pkg::SmcdCols +: smcd_pkg::SmcdCols]),
         .board_row (board_ff[r*smcd_pkg::SmcdCols +: smcd_pkg::SmcdCols]),
         .lane      (lanes[r])
      );
   end

   smcd_merge u_merge (
      .lanes (lanes),
      .pick  (pick)
   );

   // state update
   assign accept  = req_valid && req_ready;
   assign take    = rsp_valid && rsp_ready;
   assign elapsed = req_data.now_ms - last_scan_ff;
   assign scan_ok = (elapsed >= {16'd0, delay_ff});
   assign sq_bit  = 64'd1 << pick.square;
   assign lifted  = !sw_masked[pick.square];

   always_comb begin
      board_in       = board_ff;
      pending_in     = pending_ff;
      last_scan_in   = last_scan_ff;
      button_in      = button_ff;
      result.changed = 1'b0;
      result.square  = '0;
      result.lifted  = 1'b0;
      if (accept) begin
         if (req_data.func == smcd_pkg::FUNC_FILL) begin
            board_in = sw_masked;
         end else if (scan_ok) begin
            last_scan_in = req_data.now_ms;
            if (!pick.any) begin
               button_in = req_data.buttons;
            end else if (pick.square == pending_ff) begin
               // square zero also lands here when nothing is pending
               pending_in     = '0;
               board_in       = (board_ff & ~sq_bit) | (sw_masked & sq_bit);
               result.changed = 1'b1;
               result.square  = pick.square;
               result.lifted  = lifted;
            end else begin
               pending_in = pick.square;
            end
         end
      end
      result.button_state = button_in;
      result.board_state  = board_in;
   end

   // output register with skid word
   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_data_in  = out_data_ff;
      skid_data_in = skid_data_ff;
      if (take) begin
         out_valid_in = skid_valid_ff || accept;
      end else begin
         out_valid_in = out_valid_ff || accept;
      end
      if (!out_valid_ff || take) begin
         out_data_in = skid_valid_ff ? skid_data_ff : result;
      end
      if (skid_valid_ff) begin
         skid_valid_in = !take;
      end else begin
         skid_valid_in = accept && out_valid_ff && !take;
         if (accept) begin
            skid_data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= smcd_pkg::SmcdDelayReset;
         board_ff      <= '0;
         pending_ff    <= '0;
         last_scan_ff  <= '0;
         button_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         delay_ff      <= delay_in;
         board_ff      <= board_in;
         pending_ff    <= pending_in;
         last_scan_ff  <= last_scan_in;
         button_ff     <= button_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while output register empty");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.changed) |-> (rsp_data.square == '0 && !rsp_data.lifted))
      else $error("square or lifted set without a confirmed change");

   a_fill_loads_board: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == smcd_pkg::FUNC_FILL) |=> (board_ff == $past(sw_masked)))
      else $error("fill word did not load the board");

   a_unscanned_rows_low: assert property (@(posedge clock) disable iff (reset)
      (board_ff & ~smcd_pkg::SmcdRowsMask) == 64'd0)
      else $error("board bit set in a row that is not scanned");

   a_change_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && result.changed) |=> (pending_ff == '0))
      else $error("pending square kept after a confirmed change");
`endif

endmodule

>>> hw/rtl/smcd_lane.sv
// smcd_lane: difference search within one matrix row
// compares the row of the snapshot with the stored row, highest column first
// depends on smcd_pkg
module smcd_lane (
   input  logic [smcd_pkg::SmcdCols-1:0] sw_row,
   input  logic [smcd_pkg::SmcdCols-1:0] board_row,
   output smcd_pkg::smcd_lane_type       lane
);

   logic [smcd_pkg::SmcdCols-1:0] diff;

   always_comb begin
      diff = sw_row ^ board_row;
      lane.hit = |diff;
      lane.col = '0;
      // ascending sweep, so the highest set column is kept
      for (int c = 0; c < smcd_pkg::SmcdCols; c++) begin
         if (diff[c]) begin
            lane.col = smcd_pkg::SmcdColWidth'(c);
         end
      end
   end

endmodule

>>> hw/rtl/smcd_merge.sv
// smcd_merge: combines the row lanes into one square, lowest row first
// depends on smcd_pkg
module smcd_merge (
   input  smcd_pkg::smcd_lane_type lanes [smcd_pkg::SmcdRows],
   output smcd_pkg::smcd_pick_type pick
);

   always_comb begin
      pick.any = 1'b0;
      pick.square = '0;
      // descending sweep, so the lowest hitting row wins
      for (int r = smcd_pkg::SmcdRows - 1; r >= 0; r--) begin
         if (lanes[r].hit) begin
            pick.any = 1'b1;
            pick.square = {smcd_pkg::SmcdRowWidth'(r), lanes[r].col};
         end
      end
   end

endmodule

>>> verif/switch_matrix_change_debouncer_unit_tb.sv
// switch_matrix_change_debouncer_unit_tb: self-checking bench of the matrix debouncer
// directed table, then random scan/fill words over several debounce delays
// depends on smcd_pkg and switch_matrix_change_debouncer_unit
module switch_matrix_change_debouncer_unit_tb;

   localparam logic [smcd_pkg::SmcdAddrWidth-1:0] DelayAddr = {smcd_pkg::CSR_IDX_DELAY, 2'b00};
   localparam int CycleLimit = 200000;
   localparam int WordsPerPhase = 120;

   typedef struct {
      smcd_pkg::smcd_req_type word;
      logic                   typed;
      smcd_pkg::smcd_rsp_type report;
   } dir_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   smcd_pkg::smcd_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   smcd_pkg::smcd_rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [smcd_pkg::SmcdAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // tracked copy of the block state
   logic [63:0] trk_board = '0;
   logic [5:0]  trk_pending = '0;
   logic [31:0] trk_last_scan = '0;
   logic [7:0]  trk_buttons = '0;
   logic [15:0] trk_delay = smcd_pkg::SmcdDelayReset;

   smcd_pkg::smcd_rsp_type expected_reports[$];
   dir_row_type dir_table[$];
   int failures = 0;
   int words_sent = 0;
   int reports_seen = 0;
   int cycles = 0;

   switch_matrix_change_debouncer_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic smcd_pkg::smcd_req_type mk_word(logic f, logic [63:0] sw, logic [7:0] b,
                                                      logic [31:0] t);
      smcd_pkg::smcd_req_type w;
      w.func = f;
      w.switches = sw;
      w.buttons = b;
      w.now_ms = t;
      return w;
   endfunction

   function automatic smcd_pkg::smcd_rsp_type mk_report(logic c, logic [5:0] s, logic l,
                                                        logic [7:0] b, logic [63:0] bd);
      smcd_pkg::smcd_rsp_type r;
      r.changed = c;
      r.square = s;
      r.lifted = l;
      r.button_state = b;
      r.board_state = bd;
      return r;
   endfunction

   // advances the tracked state by one word and returns its report
   function automatic smcd_pkg::smcd_rsp_type predict_report(smcd_pkg::smcd_req_type w);
      logic [63:0] sw;
      logic [63:0] diff;
      logic [31:0] elapsed;
      logic [5:0]  sq;
      smcd_pkg::smcd_rsp_type r;
      sw = w.switches & smcd_pkg::SmcdRowsMask;
      r = '0;
      sq = '0;
      elapsed = w.now_ms - trk_last_scan;
      if (w.func == smcd_pkg::FUNC_FILL) begin
         trk_board = sw;
      end else if (elapsed >= {16'd0, trk_delay}) begin
         trk_last_scan = w.now_ms;
         diff = (sw ^ trk_board) & smcd_pkg::SmcdRowsMask;
         if (diff == '0) begin
            trk_buttons = w.buttons;
         end else begin
            // walk against priority so the lowest row, highest column wins
            for (int ri = 7; ri >= 0; ri--)
               for (int ci = 0; ci < 8; ci++)
                  if (diff[ri*8+ci]) sq = 6'(ri*8+ci);
            if (sq == trk_pending) begin
               trk_pending = '0;
               trk_board[sq] = sw[sq];
               r.changed = 1'b1;
               r.square = sq;
               r.lifted = ~sw[sq];
            end else begin
               trk_pending = sq;
            end
         end
      end
      r.button_state = trk_buttons;
      r.board_state = trk_board;
      return r;
   endfunction

   // mostly well-formed scans around the tracked board, some fills and noise
   function automatic smcd_pkg::smcd_req_type roll_word();
      smcd_pkg::smcd_req_type w;
      int pick;
      int sel;
      int unsigned step;
      logic [5:0] target;
      pick = $urandom_range(0, 99);
      w.func = smcd_pkg::FUNC_SCAN;
      w.buttons = 8'($urandom);
      if (pick < 8) begin
         w.func = smcd_pkg::FUNC_FILL;
         w.switches = {$urandom, $urandom};
         w.now_ms = $urandom;
      end else if (pick < 16) begin
         w.switches = {$urandom, $urandom};
         w.now_ms = $urandom;
      end else begin
         sel = $urandom_range(0, 9);
         if (sel == 0 && trk_delay != 0)
            step = $urandom_range(0, trk_delay - 1);
         else if (sel == 1)
            step = $urandom;
         else
            step = trk_delay + $urandom_range(0, 3);
         w.now_ms = trk_last_scan + step;
         sel = $urandom_range(0, 9);
         target = (trk_pending != 0 && sel < 6) ? trk_pending : 6'($urandom_range(0, 63));
         if (sel >= 8)
            w.switches = trk_board;
         else if (sel == 7)
            w.switches = trk_board ^ (64'd1 << target) ^ (64'd1 << $urandom_range(0, 63));
         else
            w.switches = trk_board ^ (64'd1 << target);
      end
      return w;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         failures++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      end
   endtask

   task automatic send_word(smcd_pkg::smcd_req_type w, logic typed,
                            smcd_pkg::smcd_rsp_type typed_report, logic rush);
      int gap;
      smcd_pkg::smcd_rsp_type predicted;
      gap = rush ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_report(w);
      expected_reports.push_back(typed ? typed_report : predicted);
      words_sent++;
   endtask

   task automatic csr_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= DelayAddr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off while the sender floods
   initial begin
      int stall;
      logic calm;
      smcd_pkg::smcd_rsp_type exp_r;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) calm = ~calm;
         stall = calm ? 0 : $urandom_range(0, 11);
         if (reports_seen == 250) stall = 90;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         reports_seen++;
         if (expected_reports.size() == 0) begin
            failures++;
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_data);
         end else begin
            exp_r = expected_reports.pop_front();
            check_field("changed", 64'(exp_r.changed), 64'(rsp_data.changed));
            check_field("square", 64'(exp_r.square), 64'(rsp_data.square));
            check_field("lifted", 64'(exp_r.lifted), 64'(rsp_data.lifted));
            check_field("button_state", 64'(exp_r.button_state), 64'(rsp_data.button_state));
            check_field("board_state", exp_r.board_state, rsp_data.board_state);
         end
      end
   end

   initial begin
      logic [15:0] delays[5];
      logic [31:0] rd;
      logic rush;
      delays = '{16'd0, 16'hFFFF, 16'd1, 16'd20, 16'($urandom_range(2, 300))};

      // reset state, debounce window, square zero, pending handoff, time wrap
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h0, 8'hA5, 32'd0),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h00, 64'h0)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h0, 8'hA5, 32'd20),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'hA5, 64'h0)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h1, 8'hFF, 32'd40),
                            1'b1, mk_report(1'b1, 6'd0, 1'b0, 8'hA5, 64'h1)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_FILL, '1, 8'h00, 32'd0),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'hA5, '1)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 32'd60),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'hA5, '1)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 32'd80),
                            1'b1, mk_report(1'b1, 6'd63, 1'b1, 8'hA5, 64'h7FFF_FFFF_FFFF_FFFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_BDFF, 8'hFF, 32'd100),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'hA5, 64'h7FFF_FFFF_FFFF_FFFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'hFF, 32'd120),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'hA5, 64'h7FFF_FFFF_FFFF_FFFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'hFF, 32'd130),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'hA5, 64'h7FFF_FFFF_FFFF_FFFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'hFF, 32'd140),
                            1'b1, mk_report(1'b1, 6'd9, 1'b1, 8'hA5, 64'h7FFF_FFFF_FFFF_FDFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'h00, 32'd160),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h00, 64'h7FFF_FFFF_FFFF_FDFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'h5A,
                                    32'hFFFF_FFF0),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h5A, 64'h7FFF_FFFF_FFFF_FDFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'h3C, 32'd3),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h5A, 64'h7FFF_FFFF_FFFF_FDFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FDFF, 8'h3C, 32'd4),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h7FFF_FFFF_FFFF_FDFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 32'd24),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h7FFF_FFFF_FFFF_FDFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 32'd44),
                            1'b1, mk_report(1'b1, 6'd9, 1'b0, 8'h3C, 64'h7FFF_FFFF_FFFF_FFFF)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_FILL, 64'h0, 8'hFF, 32'hFFFF_FFFF),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h0)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, '1, 8'h00, 32'd64),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h0)});
      // fill keeps the pending square
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_FILL, 64'h0, 8'h00, 32'd0),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h0)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h80, 8'h00, 32'd84),
                            1'b1, mk_report(1'b1, 6'd7, 1'b0, 8'h3C, 64'h80)});
      // square 0 replaces a pending square, then a second scan of it confirms
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h82, 8'h00, 32'd104),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h80)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h81, 8'h00, 32'd124),
                            1'b1, mk_report(1'b0, 6'd0, 1'b0, 8'h3C, 64'h80)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'h81, 8'h00, 32'd144),
                            1'b1, mk_report(1'b1, 6'd0, 1'b0, 8'h3C, 64'h81)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_SCAN, 64'hDEAD_BEEF_0123_4567, 8'hC3, 32'd164),
                            1'b0, mk_report(1'b0, 6'd0, 1'b0, 8'h00, 64'h0)});
      dir_table.push_back('{mk_word(smcd_pkg::FUNC_FILL, 64'h0123_4567_89AB_CDEF, 8'h81, 32'd7),
                            1'b0, mk_report(1'b0, 6'd0, 1'b0, 8'h00, 64'h0)});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].report, 1'b0);
      drain();

      rush = 1'b0;
      foreach (delays[p]) begin
         csr_access(1'b1, {16'($urandom), delays[p]}, rd);
         trk_delay = delays[p];
         csr_access(1'b0, 32'h0, rd);
         if (rd[15:0] !== delays[p]) begin
            failures++;
            $display("%0t: delay readback mismatch, expected %h, got %h", $time, delays[p],
                     rd[15:0]);
         end
         for (int n = 0; n < WordsPerPhase; n++) begin
            if (n % 40 == 0) rush = ($urandom_range(0, 3) == 0);
            // back-to-back words across the long result hold-off
            send_word(roll_word(), 1'b0, '0, rush || (words_sent >= 230 && words_sent < 330));
         end
         // sender pauses until the block has drained
         drain();
      end

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/smcd_pkg.sv
hw/rtl/smcd_lane.sv
hw/rtl/smcd_merge.sv
hw/rtl/switch_matrix_change_debouncer_unit.sv
verif/switch_matrix_change_debouncer_unit_tb.sv
